// ===== rtl/core/qpf_pkg.sv =====
package qpf_pkg;

    // Field and state widths.
    localparam int DUTY_W     = 7;
    localparam int STEP_W     = 11;
    localparam int TICK_W     = 16;
    localparam int CFG_DATA_W = 16;

    // Longest fade that the curve arithmetic is sized for.
    localparam int MAX_STEPS = 1024;
    localparam int LEVEL_MAX = 100;

    // Serial multiplier: multiplicand, multiplier and product widths.
    localparam int MUL_A_W   = 21;
    localparam int MUL_B_W   = 11;
    localparam int MUL_P_W   = 32;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    // Serial divider: dividend, divisor and quotient widths.
    localparam int DIV_N_W   = 29;
    localparam int DIV_D_W   = 22;
    localparam int DIV_Q_W   = 7;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

    // Widths of the intermediate curve terms.
    localparam int SQ_W  = 20;
    localparam int DEN_W = 21;
    localparam int NUM_W = 27;

    // Item operation codes.
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_TOTAL_STEPS = 1'b0;
    localparam logic CFG_INTERVAL    = 1'b1;

    localparam logic [STEP_W-1:0] TOTAL_STEPS_RST = STEP_W'(16);
    localparam logic [TICK_W-1:0] INTERVAL_RST    = TICK_W'(10);

    typedef struct packed {
        logic              op;
        logic [DUTY_W-1:0] level;
    } cmd_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              finished;
    } res_t;

endpackage

// ===== rtl/core/qpf_mul.sv =====
module qpf_mul
    import qpf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               done,
    output logic [MUL_P_W-1:0] product
);

    // Shift-and-add multiplier that retires one multiplier bit per cycle.
    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] count_reg;
    logic [MUL_P_W-1:0]   acc_reg;
    logic [MUL_P_W-1:0]   mcand_reg;
    logic [MUL_B_W-1:0]   mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            acc_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg   <= 1'b1;
                count_reg  <= MUL_CNT_W'(MUL_B_W);
                acc_reg    <= '0;
                mcand_reg  <= MUL_P_W'(a);
                mplier_reg <= b;
            end
            else if (busy_reg)
            begin
                if (mplier_reg[0])
                begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                count_reg  <= count_reg - MUL_CNT_W'(1);
                if (count_reg == MUL_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/core/qpf_div.sv =====
module qpf_div
    import qpf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_Q_W-1:0] quotient
);

    // Restoring divider: one quotient bit per cycle, most significant first.
    // The caller guarantees that the quotient fits in DIV_Q_W bits.
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic [DIV_N_W-1:0]   rem_reg;
    logic [DIV_N_W-1:0]   dsh_reg;
    logic [DIV_Q_W-1:0]   quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            rem_reg   <= '0;
            dsh_reg   <= '0;
            quot_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= DIV_CNT_W'(DIV_Q_W);
                rem_reg   <= dividend;
                dsh_reg   <= DIV_N_W'(divisor) << (DIV_Q_W - 1);
                quot_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_reg  <= rem_reg - dsh_reg;
                    quot_reg <= {quot_reg[DIV_Q_W-2:0], 1'b1};
                end
                else
                begin
                    quot_reg <= {quot_reg[DIV_Q_W-2:0], 1'b0};
                end
                dsh_reg   <= dsh_reg >> 1;
                count_reg <= count_reg - DIV_CNT_W'(1);
                if (count_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== rtl/core/quadratic_pwm_fade_ramp_top.sv =====
// A set-level item that ends its fade at once goes straight to ST_OUT and gives its result
// from there; one that lands on the curve passes ST_SQ, ST_DEN and ST_NUM (three passes of the
// bit-serial multiplier), then ST_DIV (the 7-bit serial divider), before ST_OUT. A countdown
// tick that does not step the fade stays in ST_IDLE and gives no result. The block takes one
// item at a time, and the next once it is back in ST_IDLE, later while a result is stalled.
// Reset clears the fade to idle with duty 0, and loads total_steps 16, interval_ticks 10.
module quadratic_pwm_fade_ramp_top
    import qpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_t                  cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_t                  res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // The sequencer walks through the curve terms: m squared, T squared, the numerator
    // d * m^2, and finally the rounded quotient (2n + T^2) / (2 T^2).
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_DEN,
        ST_NUM,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t              state_reg;

    // Configuration registers.
    logic [STEP_W-1:0]   total_steps_reg;
    logic [TICK_W-1:0]   interval_reg;

    // Fade state.
    logic [DUTY_W-1:0]   current_reg;
    logic [DUTY_W-1:0]   start_reg;
    logic [DUTY_W-1:0]   target_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                fading_reg;
    logic [TICK_W-1:0]   countdown_reg;

    // Curve terms between the serial passes.
    logic [SQ_W-1:0]     sq_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [NUM_W-1:0]    num_reg;

    // Pending result and output register.
    res_t                pend_reg;
    res_t                res_reg;
    logic                res_valid_reg;

    logic                mul_start_reg;
    logic                div_start_reg;

    // Derived values.
    logic [STEP_W-1:0]   total_eff;
    logic [DUTY_W-1:0]   level_sat;
    logic                rising;
    logic [DUTY_W-1:0]   diff;
    logic [STEP_W-1:0]   m_val;
    logic [DUTY_W-1:0]   base;
    logic [STEP_W-1:0]   step_inc;
    logic                end_set;
    logic                end_tick;
    logic                cmd_fire;
    logic                out_free;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic                mul_done;
    logic [MUL_P_W-1:0]  mul_product;

    logic [DIV_N_W-1:0]  div_dividend;
    logic [DIV_D_W-1:0]  div_divisor;
    logic                div_done;
    logic [DIV_Q_W-1:0]  div_quot;

    always_comb
    begin
        // Fades longer than the arithmetic is sized for are clamped.
        if (total_steps_reg > STEP_W'(MAX_STEPS))
        begin
            total_eff = STEP_W'(MAX_STEPS);
        end
        else
        begin
            total_eff = total_steps_reg;
        end

        if (cmd.level > DUTY_W'(LEVEL_MAX))
        begin
            level_sat = DUTY_W'(LEVEL_MAX);
        end
        else
        begin
            level_sat = cmd.level;
        end

        // A falling fade mirrors the step and measures from the target end.
        rising = (target_reg >= start_reg);
        if (rising)
        begin
            diff  = target_reg - start_reg;
            m_val = step_reg;
            base  = start_reg;
        end
        else
        begin
            diff  = start_reg - target_reg;
            m_val = total_eff - step_reg;
            base  = target_reg;
        end

        step_inc = step_reg + STEP_W'(1);

        // A set-level item starts at step one and steps once at once, so it lands on step two.
        end_set  = (STEP_W'(2) >= total_eff) || (current_reg == level_sat);
        end_tick = (step_inc >= total_eff) || (current_reg == target_reg);
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign out_free  = !res_valid_reg || res_ready;
    assign cfg_ready = 1'b1;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (state_reg)
            ST_SQ:
            begin
                mul_a = MUL_A_W'(m_val);
                mul_b = MUL_B_W'(m_val);
            end
            ST_DEN:
            begin
                mul_a = MUL_A_W'(total_eff);
                mul_b = MUL_B_W'(total_eff);
            end
            ST_NUM:
            begin
                mul_a = MUL_A_W'(sq_reg);
                mul_b = MUL_B_W'(diff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounding half away from zero: q = (2n + D) / (2D).
    assign div_dividend = DIV_N_W'({num_reg, 1'b0}) + DIV_N_W'(den_reg);
    assign div_divisor  = DIV_D_W'({den_reg, 1'b0});

    qpf_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    qpf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            total_steps_reg <= TOTAL_STEPS_RST;
            interval_reg    <= INTERVAL_RST;
            current_reg     <= '0;
            start_reg       <= '0;
            target_reg      <= '0;
            step_reg        <= '0;
            fading_reg      <= 1'b0;
            countdown_reg   <= '0;
            sq_reg          <= '0;
            den_reg         <= '0;
            num_reg         <= '0;
            pend_reg        <= '0;
            res_reg         <= '0;
            res_valid_reg   <= 1'b0;
            mul_start_reg   <= 1'b0;
            div_start_reg   <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;

            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_TOTAL_STEPS: total_steps_reg <= cfg_data[STEP_W-1:0];
                    CFG_INTERVAL:    interval_reg    <= cfg_data[TICK_W-1:0];
                    default:         ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        if (cmd.op == OP_SET)
                        begin
                            // A new level restarts the fade from the present duty.
                            start_reg  <= current_reg;
                            target_reg <= level_sat;
                            step_reg   <= STEP_W'(2);
                            if (end_set)
                            begin
                                current_reg       <= level_sat;
                                fading_reg        <= 1'b0;
                                countdown_reg     <= '0;
                                pend_reg.duty     <= level_sat;
                                pend_reg.finished <= 1'b1;
                                state_reg         <= ST_OUT;
                            end
                            else
                            begin
                                mul_start_reg <= 1'b1;
                                state_reg     <= ST_SQ;
                            end
                        end
                        else if (fading_reg)
                        begin
                            if (countdown_reg <= TICK_W'(1))
                            begin
                                step_reg <= step_inc;
                                if (end_tick)
                                begin
                                    current_reg       <= target_reg;
                                    fading_reg        <= 1'b0;
                                    countdown_reg     <= '0;
                                    pend_reg.duty     <= target_reg;
                                    pend_reg.finished <= 1'b1;
                                    state_reg         <= ST_OUT;
                                end
                                else
                                begin
                                    mul_start_reg <= 1'b1;
                                    state_reg     <= ST_SQ;
                                end
                            end
                            else
                            begin
                                countdown_reg <= countdown_reg - TICK_W'(1);
                            end
                        end
                    end
                end
                ST_SQ:
                begin
                    if (mul_done)
                    begin
                        sq_reg        <= mul_product[SQ_W-1:0];
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_DEN;
                    end
                end
                ST_DEN:
                begin
                    if (mul_done)
                    begin
                        den_reg       <= mul_product[DEN_W-1:0];
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_NUM;
                    end
                end
                ST_NUM:
                begin
                    if (mul_done)
                    begin
                        num_reg       <= mul_product[NUM_W-1:0];
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        current_reg       <= base + DUTY_W'(div_quot);
                        fading_reg        <= 1'b1;
                        countdown_reg     <= interval_reg;
                        pend_reg.duty     <= base + DUTY_W'(div_quot);
                        pend_reg.finished <= 1'b0;
                        state_reg         <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    // Hold the result until the output register is free.
                    if (out_free)
                    begin
                        res_reg       <= pend_reg;
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/core/qpf_checker.sv =====
module qpf_checker
    import qpf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input cmd_t cmd,
    input logic res_valid,
    input logic res_ready,
    input res_t res,
    input logic cfg_ready
);

    // A stalled result keeps its value.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // The duty never leaves the percent range.
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.duty <= DUTY_W'(LEVEL_MAX))
        else $error("duty above range");

    // A set-level item always produces work, so the block is busy right after it.
    a_set_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd.op == OP_SET |=> !cmd_ready)
        else $error("block idle after a set-level item");

    // The configuration port never stalls.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind quadratic_pwm_fade_ramp_top qpf_checker u_qpf_checker (.*);
